FILE: rtl/smu_pkg.sv
// segmented memory unit package: op and status codes, sizes, state encoding
// no dependencies
package smu_pkg;
    localparam int SEG_COUNT = 64;
    localparam int SEG_WORDS = 256;
    localparam int SEG_W     = 6;
    localparam int IDX_W     = 8;
    localparam int LEN_W     = 9;
    localparam int ADDR_W    = SEG_W + IDX_W;
    localparam int CNT_W     = 7;

    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_STORE = 3'd1;
    localparam logic [2:0] OP_MAP   = 3'd2;
    localparam logic [2:0] OP_UNMAP = 3'd3;
    localparam logic [2:0] OP_PROG  = 3'd4;
    localparam logic [2:0] OP_BOOT  = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNMAPPED  = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_ZERO      = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;
    localparam logic [2:0] ST_SIZE      = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_ZERO = 5'b00100,
        S_COPY = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [31:0]       wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;
endpackage

FILE: rtl/segmented_memory_unit.sv
// top level: segment table, boot packer and sequencer around the word store
// depends on smu_pkg, smu_word_ram, smu_id_queue
//
// Commands are taken while busy is low and each gives one result, shown for
// one cycle with done high; the receiver cannot stall it. Load, store, unmap,
// boot byte and failed commands go from the read state straight to done. Map
// zeroes each word of the new segment through the single write port. Load
// program copies each word into segment zero as a read then a write on the
// word store. No clearing pass after reset.
module segmented_memory_unit
    import smu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       op,
    input  logic [5:0]       segment,
    input  logic [7:0]       index,
    input  logic [31:0]      store_value,
    input  logic [8:0]       map_size,
    input  logic [7:0]       boot_byte,
    output logic             done,
    output logic [31:0]      read_data,
    output logic [5:0]       new_segment,
    output logic [2:0]       status
);
    state_t           state_reg, state_next;
    logic [LEN_W-1:0] len_tab [SEG_COUNT];
    logic [LEN_W-1:0] len_rd_reg;
    logic [LEN_W-1:0] len0_reg;
    logic [SEG_COUNT-1:0] mapped_reg;
    logic [CNT_W-1:0] fresh_reg;
    logic [1:0]       phase_reg;
    logic [23:0]      part_reg;
    logic [2:0]       op_reg;
    logic [SEG_W-1:0] seg_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [31:0]      val_reg;
    logic             from_q_reg;
    logic [SEG_W-1:0] id_reg;
    logic [LEN_W-1:0] cnt_reg, lim_reg;
    logic             rd_ph_reg, load_reg;
    logic [2:0]       st_reg;
    logic [5:0]       ns_reg;
    mem_req_t         req;
    logic [31:0]      rdata;
    logic             q_push, q_pop, q_empty, q_full;
    logic [SEG_W-1:0] q_head;
    logic             seg_ok, accept, map_go;
    logic             ls_hit, map_ok, prog_ok;
    logic [LEN_W-1:0] seg_len;
    logic [SEG_W-1:0] map_id;

    smu_word_ram u_ram (.clk(clk), .req(req), .rdata(rdata));
    smu_id_queue u_q (.clk(clk), .rst_n(rst_n), .push(q_push), .push_id(segment),
        .pop(q_pop), .head_id(q_head), .empty(q_empty), .full(q_full));

    assign accept  = start && !busy;
    assign busy    = (state_reg != S_IDLE);
    assign seg_ok  = mapped_reg[segment];
    assign done    = (state_reg == S_DONE);
    assign read_data   = load_reg ? rdata : '0;
    assign new_segment = ns_reg;
    assign status      = st_reg;

    // segment length is registered at accept and used in the read state; segment zero lives in a register
    assign seg_len = (seg_reg == '0) ? len0_reg : len_rd_reg;
    assign map_id  = from_q_reg ? q_head : id_reg;
    assign ls_hit  = (state_reg == S_READ) && (op_reg == OP_LOAD || op_reg == OP_STORE)
                     && st_reg == ST_OK && {1'b0, idx_reg} < seg_len;
    assign map_ok  = (state_reg == S_READ) && op_reg == OP_MAP && st_reg == ST_OK;
    assign prog_ok = (state_reg == S_READ) && op_reg == OP_PROG && id_reg != '0;

    assign map_go = accept && op == OP_MAP && map_size <= LEN_W'(SEG_WORDS)
                    && (!q_empty || fresh_reg < CNT_W'(SEG_COUNT));
    assign q_pop  = map_go && !q_empty;
    assign q_push = accept && op == OP_UNMAP && segment != '0 && seg_ok && !q_full;

    always_comb
    begin
        req = '0;
        if (ls_hit)
        begin
            req.raddr = {seg_reg, idx_reg};
            req.re    = (op_reg == OP_LOAD);
            req.waddr = {seg_reg, idx_reg};
            req.wdata = val_reg;
            req.we    = (op_reg == OP_STORE);
        end
        if (accept && op == OP_BOOT && phase_reg == 2'd3 && len0_reg < LEN_W'(SEG_WORDS))
        begin
            req.we    = 1'b1;
            req.waddr = {SEG_W'(0), len0_reg[IDX_W-1:0]};
            req.wdata = {part_reg, boot_byte};
        end
        if (state_reg == S_ZERO)
        begin
            req.we    = 1'b1;
            req.waddr = {id_reg, cnt_reg[IDX_W-1:0]};
            req.wdata = '0;
        end
        if (state_reg == S_COPY)
        begin
            req.re    = !rd_ph_reg;
            req.raddr = {id_reg, cnt_reg[IDX_W-1:0]};
            req.we    = rd_ph_reg;
            req.waddr = {SEG_W'(0), cnt_reg[IDX_W-1:0]};
            req.wdata = rdata;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_READ;
            S_READ:
            begin
                if (map_ok && lim_reg != '0)
                    state_next = S_ZERO;
                else if (prog_ok && seg_len != '0)
                    state_next = S_COPY;
                else
                    state_next = S_DONE;
            end
            S_ZERO: if (cnt_reg + 1'b1 >= lim_reg) state_next = S_DONE;
            S_COPY: if (rd_ph_reg && cnt_reg + 1'b1 >= lim_reg) state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // segment length table: written when a map is granted in the read state, read at accept
    always_ff @(posedge clk)
    begin
        if (map_ok)
        begin
            len_tab[map_id] <= lim_reg;
        end
        if (accept)
        begin
            len_rd_reg <= len_tab[segment];
        end
    end

    // segment table and control updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mapped_reg <= SEG_COUNT'(1);
            len0_reg   <= '0;
            fresh_reg  <= CNT_W'(1);
            phase_reg  <= '0;
            part_reg   <= '0;
            op_reg     <= '0;
            seg_reg    <= '0;
            idx_reg    <= '0;
            val_reg    <= '0;
            from_q_reg <= 1'b0;
            id_reg     <= '0;
            cnt_reg    <= '0;
            lim_reg    <= '0;
            rd_ph_reg  <= 1'b0;
            load_reg   <= 1'b0;
            st_reg     <= ST_OK;
            ns_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                op_reg     <= op;
                seg_reg    <= segment;
                idx_reg    <= index;
                val_reg    <= store_value;
                from_q_reg <= 1'b0;
                id_reg     <= '0;
                cnt_reg    <= '0;
                lim_reg    <= '0;
                st_reg     <= ST_OK;
                ns_reg     <= '0;
                load_reg   <= 1'b0;
                rd_ph_reg  <= 1'b0;
                case (op)
                    OP_LOAD, OP_STORE:
                    begin
                        if (!seg_ok) st_reg <= ST_UNMAPPED;
                    end
                    OP_MAP:
                    begin
                        if (map_size > LEN_W'(SEG_WORDS)) st_reg <= ST_SIZE;
                        else if (!map_go) st_reg <= ST_EXHAUSTED;
                        else
                        begin
                            if (q_empty)
                            begin
                                id_reg    <= fresh_reg[SEG_W-1:0];
                                fresh_reg <= fresh_reg + 1'b1;
                            end
                            else
                            begin
                                from_q_reg <= 1'b1;
                            end
                            lim_reg <= map_size;
                        end
                    end
                    OP_UNMAP:
                    begin
                        if (segment == '0) st_reg <= ST_ZERO;
                        else if (!seg_ok) st_reg <= ST_UNMAPPED;
                        else mapped_reg[segment] <= 1'b0;
                    end
                    OP_PROG:
                    begin
                        if (segment != '0)
                        begin
                            if (!seg_ok) st_reg <= ST_UNMAPPED;
                            else id_reg <= segment;
                        end
                    end
                    OP_BOOT:
                    begin
                        if (phase_reg != 2'd3)
                        begin
                            part_reg  <= {part_reg[15:0], boot_byte};
                            phase_reg <= phase_reg + 1'b1;
                        end
                        else
                        begin
                            if (len0_reg < LEN_W'(SEG_WORDS)) len0_reg <= len0_reg + 1'b1;
                            else st_reg <= ST_SIZE;
                            part_reg  <= '0;
                            phase_reg <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            else if (state_reg == S_READ)
            begin
                if ((op_reg == OP_LOAD || op_reg == OP_STORE) && st_reg == ST_OK)
                begin
                    if ({1'b0, idx_reg} >= seg_len) st_reg <= ST_RANGE;
                    else load_reg <= (op_reg == OP_LOAD);
                end
                if (map_ok)
                begin
                    id_reg <= map_id;
                    ns_reg <= map_id;
                    mapped_reg[map_id] <= 1'b1;
                end
                if (prog_ok)
                begin
                    lim_reg  <= seg_len;
                    len0_reg <= seg_len;
                end
            end
            else if (state_reg == S_ZERO)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (state_reg == S_COPY)
            begin
                rd_ph_reg <= !rd_ph_reg;
                if (rd_ph_reg) cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end
endmodule

FILE: rtl/smu_word_ram.sv
// word store of all segments: one write port and one registered read port
// depends on smu_pkg
module smu_word_ram
    import smu_pkg::*;
(
    input  logic        clk,
    input  mem_req_t    req,
    output logic [31:0] rdata
);
    logic [31:0] mem [SEG_COUNT*SEG_WORDS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end
endmodule

FILE: rtl/smu_id_queue.sv
// fifo of recycled segment identifiers, oldest first; the popped identifier
// shows on head_id in the cycle after pop
// depends on smu_pkg
module smu_id_queue
    import smu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [SEG_W-1:0] push_id,
    input  logic             pop,
    output logic [SEG_W-1:0] head_id,
    output logic             empty,
    output logic             full
);
    logic [SEG_W-1:0] q [SEG_COUNT];
    logic [SEG_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SEG_W-1:0] head_id_reg;

    assign head_id = head_id_reg;
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(SEG_COUNT));

    always_comb
    begin
        head_next  = pop ? head_reg + 1'b1 : head_reg;
        tail_next  = push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q[tail_reg] <= push_id;
        end
        if (pop)
        begin
            head_id_reg <= q[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end
endmodule

FILE: rtl/smu_checker.sv
// port-level checks for segmented_memory_unit, bound to the top level
// depends on smu_pkg
module smu_checker
    import smu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] read_data,
    input logic [5:0]  new_segment,
    input logic [2:0]  status
);
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("item not taken");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result outside an item");
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("not idle after result");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status <= ST_SIZE) else $error("bad status");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> read_data == '0 && new_segment == '0)
        else $error("data on failed item");
endmodule

bind segmented_memory_unit smu_checker u_smu_checker (.*);
